[hdl/ptrd_pkg.sv]
`default_nettype none

package ptrd_pkg;

  // datapath sizing
  localparam int ACT_WIDTH = 16;
  localparam int ACC_WIDTH = 32;
  localparam int SUM_W     = ((ACC_WIDTH > ACT_WIDTH) ? ACC_WIDTH : ACT_WIDTH) + 1;
  localparam int ALPHA_W   = 16;
  localparam int PROD_W    = ACC_WIDTH + ALPHA_W;
  localparam int FIN_W     = ((ACC_WIDTH + 6) > 33) ? (ACC_WIDTH + 6) : 33;
  localparam int RES_W     = 32;

  // rounding of the Q.20 product down to Q24.8
  localparam int FRAC_SHIFT = 12;
  localparam int ROUND_HALF = 2048;

  // front to back queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic signed [ALPHA_W-1:0] ALPHA_RESET = 16'sd4096;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SCALE_ALPHA = 2'd0,
    REG_BIAS_ENABLE = 2'd1
  } cfg_reg_t;

  // trit decode
  typedef enum logic [1:0] {
    TRIT_NONE = 2'b00,
    TRIT_ADD  = 2'b01,
    TRIT_SUB  = 2'b10
  } trit_op_t;

  typedef struct packed {
    logic [7:0]         weight_byte;
    logic signed [15:0] act_0;
    logic signed [15:0] act_1;
    logic signed [15:0] act_2;
    logic signed [15:0] act_3;
    logic signed [15:0] row_bias;
    logic               last_of_row;
  } in_item_t;

  typedef struct packed {
    logic signed [RES_W-1:0] row_result;
    logic                    saturated;
  } out_item_t;

  // classified item held in the queue
  typedef struct packed {
    trit_op_t [3:0]             ops;
    logic     [3:0][SUM_W-1:0]  acts;
    logic signed [15:0]         row_bias;
    logic                       last;
  } q_item_t;

  // finished row sum handed to the scaler
  typedef struct packed {
    logic                        valid;
    logic signed [ACC_WIDTH-1:0] acc;
    logic                        sat;
    logic signed [15:0]          bias;
  } row_done_t;

  // activation to accumulator operand width
  localparam int ACT_SIGN_BIT = (ACT_WIDTH <= 16) ? (ACT_WIDTH - 1) : 15;

  function automatic logic [SUM_W-1:0] act_ext(input logic [15:0] a);
    logic [SUM_W-1:0] r;
    r = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (i < ACT_WIDTH && i < 16) begin
        r[i] = a[i];
      end else if (i < ACT_WIDTH) begin
        r[i] = 1'b0;
      end else begin
        r[i] = (ACT_WIDTH <= 16) ? a[ACT_SIGN_BIT] : 1'b0;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/packed_ternary_row_dot_product.sv]
`default_nettype none

// channel  direction  handshake             payload
// in       input      in_valid / in_stall   in_data (in_item_t)
// out      output     out_valid / out_stall out_data (out_item_t)
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one beat per cycle in unless stalled; the four-lane saturating sum updates per beat
// after its last beat, a row result passes hand-off, multiply and round/output registers
// synchronous reset clears the row sum and flag, alpha goes to 1.0 and bias is off
// in_stall rises only when the four-entry queue in front of the accumulator is full
// a stalled output holds up row ends only; beats ahead of a held row end keep accumulating

module packed_ternary_row_dot_product
  import ptrd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic signed [ALPHA_W-1:0] scale_alpha;
  logic                      bias_enable;

  logic      q_full;
  logic      q_push;
  q_item_t   q_in;
  logic      q_pop;
  logic      q_valid;
  q_item_t   q_head;
  row_done_t done;
  logic      done_take;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_alpha <= ALPHA_RESET;
      bias_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SCALE_ALPHA: scale_alpha <= cfg_data;
        REG_BIAS_ENABLE: bias_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ptrd_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  ptrd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_head)
  );

  ptrd_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .done      (done),
    .done_take (done_take)
  );

  ptrd_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .scale_alpha (scale_alpha),
    .bias_enable (bias_enable),
    .done        (done),
    .done_take   (done_take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

[hdl/ptrd_queue.sv]
`default_nettype none

module ptrd_queue
  import ptrd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire q_item_t push_item,
  output logic         full,
  input  wire logic    pop,
  output logic         head_valid,
  output q_item_t      head_item
);

  q_item_t             entries [QDEPTH];
  logic [QPTR_W-1:0]   head;
  logic [QPTR_W-1:0]   tail;
  logic [QCNT_W-1:0]   count;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_item  = entries[head];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + 1'b1;
      end
      if (pop) begin
        head <= head + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/ptrd_front.sv]
`default_nettype none

module ptrd_front
  import ptrd_pkg::*;
(
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  input  wire logic     q_full,
  output logic          q_push,
  output q_item_t       q_item
);

  logic [3:0][15:0] acts_raw;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  assign acts_raw = {in_data.act_3, in_data.act_2, in_data.act_1, in_data.act_0};

  // trit decode and operand extension per lane
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      unique case (in_data.weight_byte[2*k +: 2])
        TRIT_ADD: q_item.ops[k] = TRIT_ADD;
        TRIT_SUB: q_item.ops[k] = TRIT_SUB;
        default:  q_item.ops[k] = TRIT_NONE;
      endcase
      q_item.acts[k] = act_ext(acts_raw[k]);
    end
    q_item.row_bias = in_data.row_bias;
    q_item.last     = in_data.last_of_row;
  end

endmodule

`default_nettype wire

[hdl/ptrd_accum.sv]
`default_nettype none

module ptrd_accum
  import ptrd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    q_valid,
  input  wire q_item_t q_item,
  output logic         q_pop,
  output row_done_t    done,
  input  wire logic    done_take
);

  localparam logic signed [SUM_W-1:0] ACC_HI =
    {{(SUM_W - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_LO =
    {{(SUM_W - ACC_WIDTH + 1){1'b1}}, {(ACC_WIDTH - 1){1'b0}}};

  logic signed [ACC_WIDTH-1:0] acc;
  logic                        acc_sat;

  logic                        done_valid;
  logic signed [ACC_WIDTH-1:0] done_acc;
  logic                        done_sat;
  logic signed [15:0]          done_bias;

  logic signed [SUM_W-1:0]     chain [5];
  logic signed [SUM_W-1:0]     sum   [4];
  logic [3:0]                  step_sat;
  logic signed [ACC_WIDTH-1:0] acc_next;
  logic                        sat_next;

  // four lanes applied in trit order, clamped after each
  always_comb begin
    chain[0] = SUM_W'(acc);
    for (int k = 0; k < 4; k++) begin
      case (q_item.ops[k])
        TRIT_ADD: sum[k] = chain[k] + $signed(q_item.acts[k]);
        TRIT_SUB: sum[k] = chain[k] - $signed(q_item.acts[k]);
        default:  sum[k] = chain[k];
      endcase
      step_sat[k] = 1'b0;
      if (sum[k] > ACC_HI) begin
        chain[k+1]  = ACC_HI;
        step_sat[k] = 1'b1;
      end else if (sum[k] < ACC_LO) begin
        chain[k+1]  = ACC_LO;
        step_sat[k] = 1'b1;
      end else begin
        chain[k+1] = sum[k];
      end
    end
    acc_next = chain[4][ACC_WIDTH-1:0];
    sat_next = acc_sat || (step_sat != 4'b0000);
  end

  // a row end waits only for the hand-off register
  assign q_pop = q_valid && (!q_item.last || !done_valid || done_take);

  // row accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      acc_sat <= 1'b0;
    end else if (q_pop) begin
      if (q_item.last) begin
        acc     <= '0;
        acc_sat <= 1'b0;
      end else begin
        acc     <= acc_next;
        acc_sat <= sat_next;
      end
    end
  end

  // hand-off register toward the scaler
  always_ff @(posedge clk) begin
    if (rst) begin
      done_valid <= 1'b0;
    end else if (q_pop && q_item.last) begin
      done_valid <= 1'b1;
    end else if (done_take) begin
      done_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.last) begin
      done_acc  <= acc_next;
      done_sat  <= sat_next;
      done_bias <= q_item.row_bias;
    end
  end

  assign done = '{valid: done_valid, acc: done_acc, sat: done_sat, bias: done_bias};

endmodule

`default_nettype wire

[hdl/ptrd_scale.sv]
`default_nettype none

module ptrd_scale
  import ptrd_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic signed [ALPHA_W-1:0] scale_alpha,
  input  wire logic                      bias_enable,
  input  wire row_done_t                 done,
  output logic                           done_take,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output out_item_t                      out_data
);

  localparam logic signed [FIN_W-1:0] RES_HI =
    {{(FIN_W - RES_W + 1){1'b0}}, {(RES_W - 1){1'b1}}};
  localparam logic signed [FIN_W-1:0] RES_LO =
    {{(FIN_W - RES_W + 1){1'b1}}, {(RES_W - 1){1'b0}}};

  logic                       s1_valid;
  logic signed [PROD_W-1:0]   s1_prod;
  logic signed [15:0]         s1_bias;
  logic                       s1_sat;
  logic                       s1_go;

  logic signed [ACC_WIDTH-1:0] mul_a;
  logic signed [PROD_W-1:0]    prod;
  logic signed [PROD_W:0]      rounded;
  logic signed [PROD_W:0]      shifted;
  logic signed [FIN_W-1:0]     fin_sum;
  logic signed [RES_W-1:0]     fin_val;
  logic                        fin_sat;

  assign s1_go     = s1_valid && (!out_valid || !out_stall);
  assign done_take = done.valid && (!s1_valid || s1_go);

  // scale multiply
  assign mul_a = done.acc;
  assign prod  = PROD_W'(mul_a) * PROD_W'(scale_alpha);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (done_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_take) begin
      s1_prod <= prod;
      s1_bias <= bias_enable ? done.bias : 16'sd0;
      s1_sat  <= done.sat;
    end
  end

  // round half up to Q24.8, add bias, clamp to 32 bits
  always_comb begin
    rounded = (PROD_W + 1)'(s1_prod) + (PROD_W + 1)'(ROUND_HALF);
    shifted = rounded >>> FRAC_SHIFT;
    fin_sum = FIN_W'($signed(shifted[PROD_W-FRAC_SHIFT:0])) + FIN_W'(s1_bias);
    fin_sat = s1_sat;
    if (fin_sum > RES_HI) begin
      fin_val = RES_HI[RES_W-1:0];
      fin_sat = 1'b1;
    end else if (fin_sum < RES_LO) begin
      fin_val = RES_LO[RES_W-1:0];
      fin_sat = 1'b1;
    end else begin
      fin_val = fin_sum[RES_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_data.row_result <= fin_val;
      out_data.saturated  <= fin_sat;
    end
  end

endmodule

`default_nettype wire
